>>> hw/rtl/mp2_pkg.sv
// Package for the 2x2 stride-2 max pooling stream block.
// Holds the parameter defaults, the configuration register map and the pooling floor.
// No dependencies.
package mp2_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_IMAGE_SIZE_DEF = 256;
  localparam int PIXEL_WIDTH_DEF    = 32;

  // Configuration register widths and map
  localparam int CHAN_W     = 16;
  localparam int SIZE_W     = 9;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 1'd1;

  localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RST = 16'd1;
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST    = 9'd256;

  // Floor is -10000 in Q16.16, i.e. -655360000; it fits in 31 signed bits
  localparam logic signed [63:0] POOL_FLOOR_64  = -64'sd655360000;
  localparam int                 FLOOR_MIN_BITS = 31;

endpackage

>>> hw/rtl/maxpool_2x2_stream.sv
// Top level of the 2x2 stride-2 max pooling stream block.
// Holds the row-pair line buffer, the scan counters and the output register.
// Depends on mp2_pkg.
//
//  channel   dir  handshake            payload (low bits first)
//  --------  ---  -------------------  ---------------------------------
//  s_*       in   s_tvalid / s_tready  tdata: pixel_a, pixel_b
//  m_*       out  m_tvalid / m_tready  tdata: pooled_value; tlast: last_of_run
//  cfg_*     in   cfg_wr_en            cfg_index, cfg_wdata
//
// One request is taken every cycle while s_tready is high; a second-row request
// waits in the holding stage with its buffer data, then loads the output
// register when that is free. The buffer read at the request edge is the
// one read port of the line buffer; its registered data and the output register
// are the two register stages of the path. Reset clears the counters, the
// pipeline valids and loads the configuration defaults; the line buffer is not
// cleared, every entry is written on the first row of a pair before it is read.
// A stall on m_tready backs up through the holding stage into s_tready.
module maxpool_2x2_stream
  import mp2_pkg::*;
#(
  parameter int MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF,
  parameter int PIXEL_WIDTH    = PIXEL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((2*PIXEL_WIDTH+7)/8)*8-1:0]  s_tdata,   // pixel_a, pixel_b, zero pad
  // master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((PIXEL_WIDTH+7)/8)*8-1:0]    m_tdata,   // pooled_value, zero pad
  output logic                                m_tlast,   // last_of_run
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata
);

  localparam int BUF_DEPTH = MAX_IMAGE_SIZE / 2;
  localparam int CW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int PCW       = (CW + 1 > SIZE_W - 1) ? CW + 1 : SIZE_W - 1;
  localparam int OW        = ((PIXEL_WIDTH + 7) / 8) * 8;

  // Floor clipped to the most negative value when the pixel is too narrow
  localparam logic signed [PIXEL_WIDTH-1:0] FLOOR =
    (PIXEL_WIDTH >= FLOOR_MIN_BITS) ? POOL_FLOOR_64[PIXEL_WIDTH-1:0]
                                    : {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

  // Configuration registers
  logic [CHAN_W-1:0] channel_count;
  logic [SIZE_W-1:0] image_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      image_size    <= IMAGE_SIZE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_wdata[CHAN_W-1:0];
        REG_IMAGE_SIZE:    image_size    <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pairs per row (and row pairs per map): half the size, at least one,
  // saturated at the buffer depth
  logic [PCW-1:0]  half_size;
  logic [PCW-1:0]  pairs;
  logic [CHAN_W:0] chans;

  always_comb begin
    half_size = PCW'(image_size[SIZE_W-1:1]);
    if (half_size == '0)
      pairs = PCW'(1);
    else if (half_size > PCW'(BUF_DEPTH))
      pairs = PCW'(BUF_DEPTH);
    else
      pairs = half_size;
    chans = (channel_count == '0) ? (CHAN_W+1)'(1) : {1'b0, channel_count};
  end

  // Scan counters
  logic [CW-1:0]     column_pair_index;
  logic              second_row_flag;
  logic [CW-1:0]     row_pair_index;
  logic [CHAN_W-1:0] channel_index;

  logic              s_accept;
  logic              col_end, row_end, chan_end;

  assign s_accept = s_tvalid && s_tready;
  assign col_end  = (PCW'(column_pair_index) + PCW'(1)) >= pairs;
  assign row_end  = (PCW'(row_pair_index) + PCW'(1)) >= pairs;
  assign chan_end = ({1'b0, channel_index} + (CHAN_W+1)'(1)) >= chans;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pair_index <= '0;
      second_row_flag   <= 1'b0;
      row_pair_index    <= '0;
      channel_index     <= '0;
    end else if (s_accept) begin
      if (!col_end) begin
        column_pair_index <= column_pair_index + CW'(1);
      end else begin
        column_pair_index <= '0;
        second_row_flag   <= !second_row_flag;
        // advance the row pair after its second row
        if (second_row_flag) begin
          if (!row_end) begin
            row_pair_index <= row_pair_index + CW'(1);
          end else begin
            row_pair_index <= '0;
            channel_index  <= chan_end ? '0 : channel_index + CHAN_W'(1);
          end
        end
      end
    end
  end

  // Request stage: unpack, take the larger pixel and the floored candidate
  logic signed [PIXEL_WIDTH-1:0] pixel_a, pixel_b, pair_max, pair_fl;

  always_comb begin
    pixel_a  = s_tdata[PIXEL_WIDTH-1:0];
    pixel_b  = s_tdata[2*PIXEL_WIDTH-1:PIXEL_WIDTH];
    pair_max = (pixel_a >= pixel_b) ? pixel_a : pixel_b;
    pair_fl  = (pair_max >= FLOOR) ? pair_max : FLOOR;
  end

  // Line buffer: first-row requests write, second-row requests read. A
  // second-row read always comes at a later edge than the write of its entry,
  // so the registered read sees fresh data without forwarding.
  logic [PIXEL_WIDTH-1:0] buf_mem [BUF_DEPTH];
  logic [PIXEL_WIDTH-1:0] buf_rd;

  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (!second_row_flag)
        buf_mem[column_pair_index] <= pair_max;
      buf_rd <= buf_mem[column_pair_index];
    end
  end

  // Holding stage: second-row requests wait here, with the buffer data, for the output register
  logic                          s1_valid;
  logic signed [PIXEL_WIDTH-1:0] s1_cand;
  logic                          s1_last;
  logic                          s1_move;
  logic signed [PIXEL_WIDTH-1:0] pooled;

  assign s1_move  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || !m_tvalid || m_tready;
  assign pooled   = ($signed(buf_rd) >= s1_cand) ? $signed(buf_rd) : s1_cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= second_row_flag;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_cand <= pair_fl;
      s1_last <= col_end && row_end && chan_end;
    end
  end

  // Output register: load on a move, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= OW'($unsigned(pooled));
      m_tlast <= s1_last;
    end
  end

endmodule

>>> bench/tb_maxpool_2x2_stream.sv
// Self-checking bench for maxpool_2x2_stream: 2x2 stride-2 max pooling over a pixel-pair stream.
// A scoreboard class predicts every pooled value and tlast; tasks drive requests and registers.
// Depends on mp2_pkg and the maxpool_2x2_stream RTL.
`timescale 1ns / 100ps

module tb_maxpool_2x2_stream;
  import mp2_pkg::*;

  localparam int BUF_SLOTS    = 128;
  localparam int DRAIN_CYCLES = 4;      // holding stage and output register plus margin
  localparam int ITEM_TARGET  = 1550;
  localparam int CALM_FROM    = 1350;   // no idling on either side after this many requests
  // Pooling floor: -10000 in Q16.16
  localparam logic signed [31:0] FLOOR_Q16 = -32'sd655360000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;         // pixel_a, pixel_b
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;                // pooled_value
  logic        m_tlast;                // last_of_run
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Idle controls for the sender and the receiver; calm is shared by both
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit calm         = 1'b0;
  int settings_applied;

  maxpool_2x2_stream DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Scoreboard: mirrors the scan counters and line buffer, queues the pooled values
  class pool_scoreboard;
    typedef struct {
      logic signed [31:0] pooled;
      logic               last;
    } pooled_t;

    logic signed [31:0] line_buf [BUF_SLOTS];
    int                 col_pos, row_pos, chan_pos;
    bit                 lower_row;
    logic [CHAN_W-1:0]  chan_total;
    logic [SIZE_W-1:0]  img_size;
    pooled_t            expected_q [$];
    int                 mismatches, results_seen, runs_closed, requests_seen;

    function new();
      foreach (line_buf[i]) line_buf[i] = '0;
      col_pos = 0; row_pos = 0; chan_pos = 0; lower_row = 1'b0;
      chan_total = CHANNEL_COUNT_RST;
      img_size   = IMAGE_SIZE_RST;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_CHANNEL_COUNT) chan_total = val[CHAN_W-1:0];
      else if (idx == REG_IMAGE_SIZE) img_size = val[SIZE_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Advance the scan on one accepted request; queue a pooled value on the lower row
    function void note_request(logic signed [31:0] a, logic signed [31:0] b);
      int                 pairs, chans, slot;
      bit                 col_end, row_end, chan_end;
      logic signed [31:0] ab, pooled;
      pairs = int'(img_size) / 2;
      if (pairs == 0) pairs = 1;
      if (pairs > BUF_SLOTS) pairs = BUF_SLOTS;
      chans    = (chan_total == 0) ? 1 : int'(chan_total);
      ab       = (a > b) ? a : b;
      slot     = col_pos % BUF_SLOTS;
      col_end  = (col_pos + 1) >= pairs;
      row_end  = (row_pos + 1) >= pairs;
      chan_end = (chan_pos + 1) >= chans;
      requests_seen++;

      if (!lower_row) begin
        line_buf[slot] = ab;
      end else begin
        pooled = (ab > FLOOR_Q16) ? ab : FLOOR_Q16;
        if (line_buf[slot] > pooled) pooled = line_buf[slot];
        expected_q.push_back('{pooled, col_end && row_end && chan_end});
        if (col_end && row_end && chan_end) runs_closed++;
      end

      // Counters beyond a shrunken bound wrap at their next advance
      if (!col_end) begin
        col_pos = (col_pos + 1) % BUF_SLOTS;
      end else begin
        col_pos = 0;
        if (!lower_row) begin
          lower_row = 1'b1;
        end else begin
          lower_row = 1'b0;
          if (!row_end) begin
            row_pos = (row_pos + 1) % BUF_SLOTS;
          end else begin
            row_pos  = 0;
            chan_pos = chan_end ? 0 : (chan_pos + 1) % 65536;
          end
        end
      end
    endfunction

    function void check_result(logic [31:0] data, logic last);
      pooled_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %08h last %0b with nothing expected", data, last));
        return;
      end
      want = expected_q.pop_front();
      if (data !== want.pooled)
        report($sformatf("pooled_value expected %08h actual %08h", want.pooled, data));
      if (last !== want.last)
        report($sformatf("last_of_run expected %0b actual %0b (value %08h)",
                         want.last, last, data));
    endfunction

    function void close();
      if (expected_q.size() != 0)
        report($sformatf("%0d pooled values never arrived", expected_q.size()));
      mismatches += (expected_q.size() > 1) ? expected_q.size() - 1 : 0;
    endfunction
  endclass

  pool_scoreboard sb = new();

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check on every taken result, stall in random bursts
  int unsigned hold_cycles = 0;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    if (hold_cycles > 0) hold_cycles--;
    else if (sink_idle_en && !calm && $urandom_range(0, 7) == 0)
      hold_cycles = $urandom_range(1, 13);
    m_tready <= (hold_cycles == 0);
  end

  // Pixel picker: extremes, values around the floor, small values and raw random words
  function automatic logic [31:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return FLOOR_Q16 + $urandom_range(0, 4) - 2;
      4:       return $urandom_range(0, 4000) - 2000;
      default: return $urandom();
    endcase
  endfunction

  // Present one request, hold it until taken, then maybe idle for a burst
  task automatic send_pixels(input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = 0;
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(a, b);
    if (src_idle_en && !calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [31:0] a;
    a = pick_pixel();
    // Ties now and then
    send_pixels(a, ($urandom_range(0, 9) == 0) ? a : pick_pixel());
  endtask

  // Hold the sender until every queued result is back and the pipeline is empty
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one or both registers on consecutive edges; call only when idle
  task automatic configure(input bit do_chan, input logic [CHAN_W-1:0] chans,
                           input bit do_size, input logic [SIZE_W-1:0] size);
    if (do_chan) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_CHANNEL_COUNT;
      cfg_wdata <= chans;
      @(posedge clk);
      sb.set_register(REG_CHANNEL_COUNT, chans);
    end
    if (do_size) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_IMAGE_SIZE;
      cfg_wdata <= CFG_DATA_W'(size);
      @(posedge clk);
      sb.set_register(REG_IMAGE_SIZE, CFG_DATA_W'(size));
    end
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int               phase, cap, sent, start_runs, pick;
    bit               whole_run, do_chan, do_size;
    logic [CHAN_W-1:0] chans;
    logic [SIZE_W-1:0] size;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Prime with the reset defaults: one full row pair of a 256-wide map fills every
    // line buffer entry, so later mid-run size changes never read a stale entry.
    repeat (256) send_random();
    wait_idle();

    // Directed part, entered mid-run: row counter is past the new bound and must wrap
    configure(1'b1, 16'd2, 1'b1, 9'd2);
    send_pixels(32'h7FFF_FFFF, 32'h8000_0000);       // upper row holds the maximum
    send_pixels(32'h8000_0000, 32'h8000_0000);
    send_pixels(32'h8000_0000, 32'h8000_0000);       // all most-negative: floor wins
    send_pixels(32'h8000_0000, 32'h8000_0000);
    send_pixels(FLOOR_Q16 - 1, FLOOR_Q16 - 2);       // just below the floor
    send_pixels(FLOOR_Q16 - 1, 32'h8000_0000);
    send_pixels(FLOOR_Q16 + 1, FLOOR_Q16 + 1);       // tie, just above the floor
    send_pixels(FLOOR_Q16, 32'h8000_0000);
    wait_idle();
    // Zero channels acts as one, size zero as one pair
    configure(1'b1, 16'd0, 1'b1, 9'd0);
    send_pixels(32'h0000_0000, 32'hFFFF_FFFF);
    send_pixels(32'hFFFF_FFFF, 32'h0000_0000);
    wait_idle();
    configure(1'b0, 16'd0, 1'b1, 9'd1);              // size one rounds down to zero pairs, taken as one
    send_pixels(32'h0001_0000, 32'h0001_0000);
    send_pixels(32'h0000_8000, 32'h0000_8000);
    wait_idle();
    configure(1'b0, 16'd0, 1'b1, 9'd3);
    send_pixels(32'hFFFF_0000, 32'h0000_0001);
    send_pixels(32'hFFFE_0000, 32'hFFFF_FFFF);
    wait_idle();
    configure(1'b1, 16'd1, 1'b1, 9'd4);              // a, b and the buffer each win at least once
    send_pixels(32'h0000_0010, 32'h0000_0020);
    send_pixels(32'h0000_0300, 32'h0000_0100);
    send_pixels(32'h0000_0001, 32'h0000_0030);
    send_pixels(32'h0000_0400, 32'h0000_0002);
    send_pixels(32'h0000_0040, 32'h0000_0001);
    send_pixels(32'h0000_0001, 32'h0000_0500);
    send_pixels(32'h0000_0002, 32'h0000_0003);
    send_pixels(32'h0000_0004, 32'h0000_0001);
    wait_idle();

    // Random part: mostly whole runs at small sizes, some cut short, a few extremes
    phase = 0;
    while (sb.requests_seen < ITEM_TARGET) begin
      calm         = sb.requests_seen >= CALM_FROM;
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 19);
      if (pick < 14)       size = SIZE_W'(2 * $urandom_range(1, 8));
      else if (pick < 16)  size = SIZE_W'($urandom_range(0, 17));
      else if (pick == 16) size = 9'd256;
      else if (pick == 17) size = 9'd511;
      else if (pick == 18) size = SIZE_W'($urandom_range(257, 511));
      else                 size = SIZE_W'($urandom_range(18, 254));
      pick = $urandom_range(0, 11);
      if (pick == 0)      chans = 16'd0;
      else if (pick == 1) chans = 16'hFFFF;
      else if (pick == 2) chans = CHAN_W'($urandom_range(0, 65535));
      else                chans = CHAN_W'($urandom_range(1, 3));
      pick    = $urandom_range(0, 3);
      do_chan = pick != 1;
      do_size = pick != 2;
      whole_run = $urandom_range(0, 3) != 0;
      cap       = whole_run ? 400 : $urandom_range(1, 40);
      // Make sure the largest settings show up early, with a bounded number of requests
      if (phase == 0) begin
        chans = 16'hFFFF; size = 9'd511; do_chan = 1'b1; do_size = 1'b1; whole_run = 1'b0;
        cap = 150;
      end else if (phase == 1) begin
        chans = 16'hFFFF; size = 9'd2; do_chan = 1'b1; do_size = 1'b1; whole_run = 1'b0;
        cap = 60;
      end
      configure(do_chan, chans, do_size, size);
      start_runs = sb.runs_closed;
      sent = 0;
      while (sent < cap && sb.requests_seen < ITEM_TARGET &&
             (!whole_run || sb.runs_closed == start_runs)) begin
        calm = sb.requests_seen >= CALM_FROM;
        send_random();
        sent++;
      end
      wait_idle();
      phase++;
    end

    sb.close();
    $display("Covered %0d requests and %0d results over %0d register settings;",
             sb.requests_seen, sb.results_seen, settings_applied);
    $display("%0d runs closed with tlast, %0d mismatches.", sb.runs_closed, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
